[sv/variable_window_moving_average_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef VARIABLE_WINDOW_MOVING_AVERAGE_TOP_DEFINES_SVH
`define VARIABLE_WINDOW_MOVING_AVERAGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VWMA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VWMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vwma_pkg.sv]
package vwma_pkg;

	localparam int HISTORY_DEPTH = 20;
	localparam int SAMPLE_BITS   = 16;

	// Port field widths
	localparam int SAMPLE_W    = 16;
	localparam int CMD_W       = 8;
	localparam int AVG_W       = 16;
	localparam int WIN_NOW_W   = 5;
	localparam int IN_TDATA_W  = ((SAMPLE_W + CMD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((AVG_W + WIN_NOW_W + 7) / 8) * 8;

	// Internal widths
	localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH);
	localparam int ACC_W  = SAMPLE_BITS + WIN_W;
	localparam int SEXT_W = (SAMPLE_W > SAMPLE_BITS) ? SAMPLE_W : SAMPLE_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	localparam logic [CMD_W-1:0] CMD_WIDEN  = 8'h2B;
	localparam logic [CMD_W-1:0] CMD_NARROW = 8'h2D;

	localparam logic [WIN_W-1:0] WINDOW_MAX = WIN_W'(HISTORY_DEPTH);
	localparam logic [WIN_W-1:0] WINDOW_MIN = WIN_W'(1);
	localparam logic [WIN_W-1:0] WINDOW_AT_RESET =
		(HISTORY_DEPTH < 10) ? WIN_W'(HISTORY_DEPTH) : WIN_W'(10);

	typedef enum logic [1:0] {
		ST_SAMPLE  = 2'd0,
		ST_WIDEN   = 2'd1,
		ST_NARROW  = 2'd2,
		ST_REFUSED = 2'd3
	} status_t;

	typedef struct packed {
		logic                          is_cmd;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [WIN_W-1:0]              window;
		status_t                       status;
	} item_t;

endpackage

[sv/vwma_div.sv]
module vwma_div
	import vwma_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	input  logic [WIN_W-1:0]        divisor,
	output logic                    done,
	output logic signed [ACC_W-1:0] quotient
);

	localparam int DC_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] mag_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] div_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [DC_W-1:0]  cnt_q;

	logic [WIN_W:0] rem_sh;
	logic [WIN_W:0] diff;

	assign rem_sh = {rem_q, mag_q[ACC_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			neg_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DC_W'(ACC_W - 1));
			if (start) begin
				// Divide magnitudes, fix the sign at the end: truncates toward zero
				mag_q  <= dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
				neg_q  <= dividend[ACC_W-1];
				div_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!diff[WIN_W]) begin
					rem_q <= diff[WIN_W-1:0];
					mag_q <= {mag_q[ACC_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[WIN_W-1:0];
					mag_q <= {mag_q[ACC_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DC_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

[sv/vwma_queue.sv]
module vwma_queue
	import vwma_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t           mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != (QP_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				mem_q[wr_ptr_q] <= push_item;
				wr_ptr_q        <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/vwma_front.sv]
module vwma_front
	import vwma_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic [CMD_W-1:0]    in_cmd,
	output logic                push_valid,
	input  logic                push_ready,
	output item_t               push_item
);

	logic [WIN_W-1:0] window_q;
	logic [WIN_W-1:0] window_d;
	status_t          status_d;
	logic [SEXT_W-1:0] raw;

	assign raw = SEXT_W'(in_sample);

	// Window changes resolve here, so every queued item carries the window in force
	always_comb begin
		window_d = window_q;
		status_d = ST_SAMPLE;
		if (in_op) begin
			if (in_cmd == CMD_WIDEN && window_q < WINDOW_MAX) begin
				window_d = window_q + 1'b1;
				status_d = ST_WIDEN;
			end else if (in_cmd == CMD_NARROW && window_q > WINDOW_MIN) begin
				window_d = window_q - 1'b1;
				status_d = ST_NARROW;
			end else begin
				status_d = ST_REFUSED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_AT_RESET;
		end else if (in_valid && push_ready) begin
			window_q <= window_d;
		end
	end

	assign in_ready         = push_ready;
	assign push_valid       = in_valid;
	assign push_item.is_cmd = in_op;
	assign push_item.sample = $signed(raw[SAMPLE_BITS-1:0]);
	assign push_item.window = window_d;
	assign push_item.status = status_d;

endmodule

[sv/vwma_back.sv]
module vwma_back
	import vwma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  item_t                pop_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [AVG_W-1:0]     out_average,
	output logic [WIN_NOW_W-1:0] out_window,
	output status_t              out_status
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROT,
		B_DIV,
		B_OUT
	} state_t;

	state_t                        state_q;
	logic signed [SAMPLE_BITS-1:0] hist_q [HISTORY_DEPTH];
	logic signed [ACC_W-1:0]       acc_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [WIN_W-1:0]              win_q;
	status_t                       stat_q;
	logic [AVG_W-1:0]              avg_q;
	logic                          start_q;
	logic                          out_valid_q;
	logic [AVG_W-1:0]              out_avg_q;
	logic [WIN_NOW_W-1:0]          out_win_q;
	status_t                       out_stat_q;

	logic                    div_done;
	logic signed [ACC_W-1:0] div_quot;
	logic                    out_free;
	logic                    out_load;
	logic signed [ACC_W-1:0] tap;

	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == B_OUT) && out_free;
	assign pop_ready = (state_q == B_IDLE);
	assign tap       = ACC_W'(hist_q[0]);

	vwma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (acc_q),
		.divisor  (win_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			acc_q       <= '0;
			cnt_q       <= '0;
			win_q       <= WINDOW_AT_RESET;
			stat_q      <= ST_SAMPLE;
			avg_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_avg_q   <= '0;
			out_win_q   <= '0;
			out_stat_q  <= ST_SAMPLE;
		end else begin
			// Kick the divider once the last entry has been summed
			start_q <= (state_q == B_ROT) && (cnt_q == CNT_W'(HISTORY_DEPTH - 1));
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						win_q  <= pop_item.window;
						stat_q <= pop_item.status;
						if (pop_item.is_cmd) begin
							avg_q   <= '0;
							state_q <= B_OUT;
						end else begin
							// Shift the new sample in; the oldest drops out
							hist_q[0] <= pop_item.sample;
							for (int i = 1; i < HISTORY_DEPTH; i++) begin
								hist_q[i] <= hist_q[i-1];
							end
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= B_ROT;
						end
					end
				end
				B_ROT: begin
					// Rotate one full turn, summing the entries inside the window at the tap
					for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
						hist_q[i] <= hist_q[i+1];
					end
					hist_q[HISTORY_DEPTH-1] <= hist_q[0];
					if (WIN_W'(cnt_q) < win_q) begin
						acc_q <= acc_q + tap;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(HISTORY_DEPTH - 1)) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (div_done) begin
						avg_q   <= AVG_W'(div_quot);
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_avg_q   <= avg_q;
						out_win_q   <= WIN_NOW_W'(win_q);
						out_stat_q  <= stat_q;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_average = out_avg_q;
	assign out_window  = out_win_q;
	assign out_status  = out_stat_q;

endmodule

[sv/variable_window_moving_average_top.sv]
// Flow: a sample transaction passes the queue, a rotation pass over the history line,
//   the one-bit-per-cycle divider and the output register; a window command skips
//   the rotation and the divider. The back end pops the next transaction only once
//   the last result is in the output register; the queue holds accepted ones meanwhile.
// Reset: arst_n clears the history to zero, the window to 10 (or HISTORY_DEPTH if smaller),
//   the queue and the output register, all at once; inputs are taken right after reset.
module variable_window_moving_average_top
	import vwma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [15:0] sample, [23:16] command_byte
	input  logic                   s_tuser,  // [0] operation
	// Result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [15:0] average, [20:16] window_now, rest zero
	output logic [1:0]             m_tuser   // [1:0] command_status
);

	// Front end: classify each transaction and settle window commands at once.
	// Each queued item carries the window in force after it, so the back end
	// never needs the window register and the two halves run apart.
	logic  push_valid;
	logic  push_ready;
	item_t push_item;

	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	logic [AVG_W-1:0]     res_average;
	logic [WIN_NOW_W-1:0] res_window;
	status_t              res_status;

	vwma_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_sample  (s_tdata[SAMPLE_W-1:0]),
		.in_cmd     (s_tdata[SAMPLE_W +: CMD_W]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Short queue: hold accepted transactions while the back end is busy
	vwma_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: shift the history, sum the window, divide, and drive the
	// output register, which decouples the result side from the work
	vwma_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_average (res_average),
		.out_window  (res_window),
		.out_status  (res_status)
	);

	// Pack result fields, lowest field first, pad with zeros
	assign m_tdata = OUT_TDATA_W'({res_window, res_average});
	assign m_tuser = res_status;

endmodule

[sv/vwma_checker.sv]
`include "variable_window_moving_average_top_defines.svh"

module vwma_checker
	import vwma_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]             m_tuser
);

	// Hold a stalled result
	`VWMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Command results carry a zero average
	`VWMA_ASSERT_NOW(a_cmd_zero_avg, m_tvalid && m_tuser != ST_SAMPLE, m_tdata[AVG_W-1:0] == '0, "command result with nonzero average")

	// A widened window is above the minimum, a narrowed one below the maximum
	`VWMA_ASSERT_NOW(a_widen_range, m_tvalid && m_tuser == ST_WIDEN, m_tdata[AVG_W +: WIN_NOW_W] != WIN_NOW_W'(1), "widened window at minimum")

	`VWMA_ASSERT_NOW(a_narrow_range, m_tvalid && m_tuser == ST_NARROW, m_tdata[AVG_W +: WIN_NOW_W] != WIN_NOW_W'(HISTORY_DEPTH), "narrowed window at maximum")

endmodule

bind variable_window_moving_average_top vwma_checker u_vwma_checker (.*);

[tb/testbench.sv]
module testbench;
	import vwma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One queued input transaction; drain_first holds it back until every
	// earlier result has come out.
	typedef struct packed {
		logic                       is_cmd;
		logic signed [SAMPLE_W-1:0] sample;
		logic [CMD_W-1:0]           cmd;
		logic                       drain_first;
	} filter_item_t;

	typedef struct packed {
		logic signed [AVG_W-1:0] average;
		logic [WIN_NOW_W-1:0]    window_now;
		status_t                 status;
	} filter_out_t;

	localparam int RANDOM_ITEMS = 1600;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;

	variable_window_moving_average_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	filter_item_t input_items[$];
	filter_out_t  expected_outputs[$];
	int           mismatch_count = 0;
	int           outputs_seen   = 0;

	// Own copy of the filter state: newest sample at index 0.
	logic signed [SAMPLE_BITS-1:0] sample_line [HISTORY_DEPTH];
	int unsigned                   window_len;

	function automatic void clear_filter_state();
		for (int i = 0; i < HISTORY_DEPTH; i++)
			sample_line[i] = '0;
		window_len = WINDOW_AT_RESET;
	endfunction

	// Apply one item to the state and return the output it must produce.
	function automatic filter_out_t next_filter_output(input filter_item_t it);
		filter_out_t r;
		longint      acc;
		r   = '0;
		acc = 0;
		if (!it.is_cmd) begin
			for (int i = HISTORY_DEPTH - 1; i > 0; i--)
				sample_line[i] = sample_line[i-1];
			sample_line[0] = SAMPLE_BITS'(it.sample);
			for (int i = 0; i < window_len; i++)
				acc += longint'(sample_line[i]);
			r.average = AVG_W'(acc / longint'(window_len));
			r.status  = ST_SAMPLE;
		end else if (it.cmd == CMD_WIDEN && window_len < HISTORY_DEPTH) begin
			window_len++;
			r.status = ST_WIDEN;
		end else if (it.cmd == CMD_NARROW && window_len > WINDOW_MIN) begin
			window_len--;
			r.status = ST_NARROW;
		end else begin
			r.status = ST_REFUSED;
		end
		r.window_now = WIN_NOW_W'(window_len);
		return r;
	endfunction

	function automatic void add_item(input logic is_cmd, input logic [SAMPLE_W-1:0] smp,
			input logic [CMD_W-1:0] cb, input logic drain);
		filter_item_t it;
		it.is_cmd      = is_cmd;
		it.sample      = smp;
		it.cmd         = cb;
		it.drain_first = drain;
		input_items.push_back(it);
	endfunction

	// Sender: bursts of random length separated by random gaps.
	filter_item_t offered_item = '0;
	int           burst_left   = 0;
	int           gap_left     = 0;
	logic         offer;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_outputs.push_back(next_filter_output(offered_item));
			// Hold the current transaction until it is taken.
			if (!s_tvalid || s_tready) begin
				offer = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (input_items.size() != 0 &&
						!(input_items[0].drain_first && expected_outputs.size() != 0)) begin
					offered_item = input_items.pop_front();
					offer = 1'b1;
					s_tdata <= IN_TDATA_W'({offered_item.cmd, offered_item.sample});
					s_tuser <= offered_item.is_cmd;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
					end else begin
						burst_left--;
					end
				end
				s_tvalid <= offer;
			end
		end
	end

	// Receiver: stall rate changes per stretch; one long hold-off fills the block up.
	int   stretch_left = 0;
	int   stall_pct    = 0;
	int   hold_left    = 0;
	logic hold_done    = 1'b0;
	logic take;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && outputs_seen >= 300) begin
				hold_done = 1'b1;
				hold_left = 1500;
			end
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(20, 300);
					case ($urandom_range(0, 3))
						0, 1: stall_pct = 0;
						2: stall_pct = 30;
						default: stall_pct = 75;
					endcase
				end
				stretch_left--;
				take = ($urandom_range(0, 99) >= stall_pct);
			end
			m_tready <= take;
		end
	end

	// Monitor: compare each result transaction against the oldest expectation.
	filter_out_t want;
	filter_out_t got;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			outputs_seen++;
			got.average    = m_tdata[AVG_W-1:0];
			got.window_now = m_tdata[AVG_W +: WIN_NOW_W];
			got.status     = status_t'(m_tuser);
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected result avg=%0d win=%0d status=%0d", $time,
					got.average, got.window_now, got.status);
				mismatch_count++;
			end else begin
				want = expected_outputs.pop_front();
				if (got.average !== want.average) begin
					$display("%0t: average expected %0d actual %0d", $time,
						want.average, got.average);
					mismatch_count++;
				end
				if (got.window_now !== want.window_now) begin
					$display("%0t: window_now expected %0d actual %0d", $time,
						want.window_now, got.window_now);
					mismatch_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: command_status expected %0d actual %0d", $time,
						want.status, got.status);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus and end of run.
	int          made;
	int          run_len;
	int          run_kind;
	int          next_drain;
	logic [CMD_W-1:0] run_cmd;

	initial begin
		clear_filter_state();

		// Directed: sample extremes, unknown bytes, widen past the limit, narrow once.
		add_item(1'b0, 16'h7FFF, '0, 1'b0);
		add_item(1'b0, 16'h8000, '0, 1'b0);
		add_item(1'b0, 16'hFFFF, '0, 1'b0);
		add_item(1'b0, 16'h0001, '0, 1'b0);
		add_item(1'b1, '0, 8'h00, 1'b0);
		add_item(1'b1, 16'hFFFF, 8'hFF, 1'b0);
		for (int i = 0; i < 11; i++)
			add_item(1'b1, '0, CMD_WIDEN, 1'b0);
		add_item(1'b0, 16'h8000, '0, 1'b0);
		add_item(1'b0, 16'h8000, '0, 1'b0);
		add_item(1'b0, 16'h7FFF, '0, 1'b0);
		add_item(1'b1, '0, CMD_NARROW, 1'b0);

		// Random: sample runs, command runs long enough to hit both window limits.
		made       = 0;
		next_drain = 0;
		while (made < RANDOM_ITEMS) begin
			run_kind = $urandom_range(0, 9);
			if (run_kind < 6) begin
				run_len = $urandom_range(1, 12);
				case ($urandom_range(0, 3))
					0: for (int i = 0; i < run_len; i++)
						add_item(1'b0, 16'h7FFF, CMD_W'($urandom_range(0, 255)),
							made + i == next_drain);
					1: for (int i = 0; i < run_len; i++)
						add_item(1'b0, 16'h8000, CMD_W'($urandom_range(0, 255)),
							made + i == next_drain);
					2: for (int i = 0; i < run_len; i++)
						add_item(1'b0, SAMPLE_W'(int'($urandom_range(0, 16)) - 8),
							'0, made + i == next_drain);
					default: for (int i = 0; i < run_len; i++)
						add_item(1'b0, SAMPLE_W'($urandom_range(0, 65535)),
							CMD_W'($urandom_range(0, 255)), made + i == next_drain);
				endcase
			end else if (run_kind < 9) begin
				run_len = $urandom_range(1, 22);
				run_cmd = ($urandom_range(0, 1) == 0) ? CMD_WIDEN : CMD_NARROW;
				for (int i = 0; i < run_len; i++)
					add_item(1'b1, SAMPLE_W'($urandom_range(0, 65535)), run_cmd,
						made + i == next_drain);
			end else begin
				run_len = 1;
				add_item(1'b1, SAMPLE_W'($urandom_range(0, 65535)),
					CMD_W'($urandom_range(0, 255)), made == next_drain);
			end
			if (made + run_len > next_drain)
				next_drain += 550;
			made += run_len;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (input_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
